@@ hw/rtl/psaw_pkg.sv @@
package psaw_pkg;

   localparam int FRAC_BITS = 16;
   localparam int PHASE_W   = FRAC_BITS;
   localparam int MODE_W    = 2;
   localparam int AMP_W     = 17;
   localparam int LFO_AMP_W = 24;
   localparam int AUDIO_W   = 18;
   localparam int LFO_W     = 25;
   localparam int PROD_W    = PHASE_W + AMP_W + 1;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [MODE_W-1:0] MODE_PULSE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SAW   = 2'd1;

   localparam logic [CSR_IDX_W-1:0] REG_WAVE_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_INC  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DUTY       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AMPLITUDE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LFO_AMP    = 3'd4;

   localparam logic [PHASE_W-1:0] DUTY_MIN =
      PHASE_W'((5 * (1 << FRAC_BITS) + 50) / 100);
   localparam logic [PHASE_W-1:0] DUTY_MAX =
      PHASE_W'((95 * (1 << FRAC_BITS) + 50) / 100);

   localparam logic [MODE_W-1:0]    RST_MODE    = MODE_PULSE;
   localparam logic [PHASE_W-1:0]   RST_INC     = 16'd1311;
   localparam logic [PHASE_W-1:0]   RST_DUTY    = 16'd32768;
   localparam logic [AMP_W-1:0]     RST_AMP     = 17'd65536;
   localparam logic [LFO_AMP_W-1:0] RST_LFO_AMP = 24'd1638400;

   localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1 << (FRAC_BITS - 1));

   typedef struct packed {
      logic [MODE_W-1:0]    wave_mode;
      logic [PHASE_W-1:0]   phase_increment;
      logic [PHASE_W-1:0]   duty_cycle;
      logic [AMP_W-1:0]     amplitude;
      logic [LFO_AMP_W-1:0] lfo_amplitude;
   } psaw_cfg_type;

   // one queued tick, already classified by the front end
   typedef struct packed {
      logic               audio_on;
      logic               saw;
      logic               pulse_hi;
      logic [PHASE_W-1:0] phase;
      logic               lfo_on;
      logic               lfo_hi;
   } psaw_item_type;

endpackage

@@ hw/rtl/pulse_saw_oscillator_with_lfo.sv @@
// Pulse / sawtooth phase-accumulator oscillator with a square LFO.
// req_ channel: one tick per transfer, req_tdata[0] steps the audio phase,
// req_tdata[1] steps the LFO phase. rsp_ channel: one result per tick,
// rsp_tdata[17:0] audio sample (signed Q1.16), rsp_tdata[42:18] LFO
// sample (signed Q8.16); a field whose phase was not stepped reads zero.
// csr_ channel: register writes (index, data), always ready; write only
// while no tick is in flight. Indexes beyond the register list are dropped.
// Throughput: one tick per cycle while the queue has room. The front end
// advances the phases and the tick is written into the queue when it is
// transferred; the back end pops it and does one 16x18 multiply into the
// output register.
// A queue of QUEUE_DEPTH entries sits between the two; when the receiver
// stalls, the output register holds and the queue fills, then req_tready
// falls until a result is taken.
// Reset (synchronous) clears both phases and the queue and restores the
// register defaults: pulse mode, increment 1311, duty 0.5, gain 1.0,
// LFO level 25.0.
module pulse_saw_oscillator_with_lfo
   import psaw_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // step_audio, step_lfo, zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // audio_sample, lfo_sample, zero pad
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   psaw_cfg_type       cfg_ff;
   logic [PHASE_W-1:0] duty_raw, duty_clamped;
   psaw_item_type      push_item, pop_item;
   logic               push_valid, push_ready, pop_valid, pop_ready;

   assign csr_ready = 1'b1;
   assign duty_raw  = csr_data[PHASE_W-1:0];

   always_comb begin
      duty_clamped = duty_raw;
      if (duty_raw < DUTY_MIN) begin
         duty_clamped = DUTY_MIN;
      end else if (duty_raw > DUTY_MAX) begin
         duty_clamped = DUTY_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wave_mode       <= RST_MODE;
         cfg_ff.phase_increment <= RST_INC;
         cfg_ff.duty_cycle      <= RST_DUTY;
         cfg_ff.amplitude       <= RST_AMP;
         cfg_ff.lfo_amplitude   <= RST_LFO_AMP;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_WAVE_MODE: cfg_ff.wave_mode       <= csr_data[MODE_W-1:0];
            REG_PHASE_INC: cfg_ff.phase_increment <= csr_data[PHASE_W-1:0];
            REG_DUTY:      cfg_ff.duty_cycle      <= duty_clamped;
            REG_AMPLITUDE: cfg_ff.amplitude       <= csr_data[AMP_W-1:0];
            REG_LFO_AMP:   cfg_ff.lfo_amplitude   <= csr_data[LFO_AMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   psaw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   psaw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_item  (push_item),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_item  (pop_item)
   );

   psaw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      cfg_ff.duty_cycle >= DUTY_MIN && cfg_ff.duty_cycle <= DUTY_MAX)
      else $error("duty cycle outside clamp range");
`endif

endmodule

@@ hw/rtl/psaw_front.sv @@
module psaw_front
   import psaw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  psaw_cfg_type          cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  push_valid,
   input  logic                  push_ready,
   output psaw_item_type         push_item
);

   logic [PHASE_W-1:0] audio_phase_ff, audio_phase_in;
   logic [PHASE_W-1:0] lfo_phase_ff, lfo_phase_in;
   logic [PHASE_W:0]   inc_plus_one;
   logic [PHASE_W-1:0] half_inc;
   logic               step_audio, step_lfo, audio_go, accept;

   assign step_audio = req_tdata[0];
   assign step_lfo   = req_tdata[1];
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && req_tready;

   assign audio_go     = step_audio &&
                         (cfg.wave_mode == MODE_PULSE || cfg.wave_mode == MODE_SAW);
   assign inc_plus_one = {1'b0, cfg.phase_increment} + {{PHASE_W{1'b0}}, 1'b1};
   assign half_inc     = inc_plus_one[PHASE_W:1];

   always_comb begin
      audio_phase_in = audio_phase_ff;
      lfo_phase_in   = lfo_phase_ff;
      if (audio_go) begin
         audio_phase_in = audio_phase_ff + cfg.phase_increment;
      end
      if (step_lfo) begin
         lfo_phase_in = lfo_phase_ff + half_inc;
      end
   end

   always_comb begin
      push_item.audio_on = audio_go;
      push_item.saw      = (cfg.wave_mode == MODE_SAW);
      push_item.pulse_hi = (audio_phase_in < cfg.duty_cycle);
      push_item.phase    = audio_phase_in;
      push_item.lfo_on   = step_lfo;
      push_item.lfo_hi   = ~lfo_phase_in[PHASE_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         audio_phase_ff <= '0;
         lfo_phase_ff   <= '0;
      end else if (accept) begin
         audio_phase_ff <= audio_phase_in;
         lfo_phase_ff   <= lfo_phase_in;
      end
   end

`ifndef SYNTHESIS
   a_audio_hold: assert property (@(posedge clock) disable iff (reset)
      accept && !audio_go |=> $stable(audio_phase_ff))
      else $error("audio phase moved without an audio step");
`endif

endmodule

@@ hw/rtl/psaw_queue.sv @@
module psaw_queue
   import psaw_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_valid,
   output logic          wr_ready,
   input  psaw_item_type wr_item,
   output logic          rd_valid,
   input  logic          rd_ready,
   output psaw_item_type rd_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   psaw_item_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             wr_fire, rd_fire;

   assign wr_ready = (count_ff != FULL_CNT);
   assign rd_valid = (count_ff != '0);
   assign rd_item  = mem_ff[rd_ptr_ff];
   assign wr_fire  = wr_valid && wr_ready;
   assign rd_fire  = rd_valid && rd_ready;

   always_comb begin
      count_in = count_ff;
      if (wr_fire && !rd_fire) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd_fire && !wr_fire) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (wr_fire) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (rd_fire) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      !wr_ready && !rd_ready |=> $stable(count_ff))
      else $error("full queue changed without a read");
`endif

endmodule

@@ hw/rtl/psaw_back.sv @@
module psaw_back
   import psaw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  psaw_cfg_type          cfg,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  psaw_item_type         pop_item,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                       rsp_valid_ff;
   logic [AUDIO_W-1:0]         audio_ff, audio_in;
   logic [LFO_W-1:0]           lfo_ff, lfo_in;
   logic                       pop_fire;
   logic signed [PHASE_W-1:0]  centred;
   logic signed [AUDIO_W-1:0]  amp_s;
   logic signed [PROD_W-1:0]   prod, rounded;
   logic [AUDIO_W-1:0]         saw_val;
   logic [LFO_W-1:0]           lfo_amp_s;

   assign pop_ready = !rsp_valid_ff || rsp_tready;
   assign pop_fire  = pop_valid && pop_ready;

   // phase - 0.5 is the phase with its top bit inverted
   assign centred = {~pop_item.phase[PHASE_W-1], pop_item.phase[PHASE_W-2:0]};
   assign amp_s   = {1'b0, cfg.amplitude};
   assign prod    = PROD_W'(centred) * PROD_W'(amp_s);
   assign rounded = prod + ROUND_BIAS;
   assign saw_val = {rounded[FRAC_BITS +: AUDIO_W-1], 1'b0};

   assign lfo_amp_s = {1'b0, cfg.lfo_amplitude};

   always_comb begin
      audio_in = '0;
      lfo_in   = '0;
      if (pop_item.audio_on) begin
         if (pop_item.saw) begin
            audio_in = saw_val;
         end else if (pop_item.pulse_hi) begin
            audio_in = amp_s;
         end else begin
            audio_in = -amp_s;
         end
      end
      if (pop_item.lfo_on) begin
         lfo_in = pop_item.lfo_hi ? lfo_amp_s : -lfo_amp_s;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         audio_ff <= audio_in;
         lfo_ff   <= lfo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop_ready) begin
         rsp_valid_ff <= pop_valid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - AUDIO_W - LFO_W){1'b0}}, lfo_ff, audio_ff};

`ifndef SYNTHESIS
   a_audio_quiet: assert property (@(posedge clock) disable iff (reset)
      pop_fire && !pop_item.audio_on |=> rsp_tdata[AUDIO_W-1:0] == '0)
      else $error("audio sample not zero for a quiet tick");
   a_lfo_quiet: assert property (@(posedge clock) disable iff (reset)
      pop_fire && !pop_item.lfo_on |=> rsp_tdata[AUDIO_W +: LFO_W] == '0)
      else $error("lfo sample not zero for a quiet tick");
`endif

endmodule

@@ verif/tb_pulse_saw_oscillator_with_lfo.sv @@
module tb_pulse_saw_oscillator_with_lfo;
   import psaw_pkg::*;

   localparam int NUM_REGS = 5;
   localparam logic [MODE_W-1:0] MODE_SILENT = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SILENT_ALT = 2'd3;
   localparam longint FX_HALF = longint'(1) << (FRAC_BITS - 1);
   localparam longint AUDIO_HI = (longint'(1) << (AUDIO_W - 1)) - 1;
   localparam longint AUDIO_LO = -(longint'(1) << (AUDIO_W - 1));
   localparam longint LFO_HI = (longint'(1) << (LFO_W - 1)) - 1;
   localparam longint LFO_LO = -(longint'(1) << (LFO_W - 1));

   typedef struct packed {
      logic signed [AUDIO_W-1:0] audio;
      logic signed [LFO_W-1:0]   lfo;
   } osc_sample_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor state and register copies
   logic [MODE_W-1:0]    mode_reg = RST_MODE;
   logic [PHASE_W-1:0]   inc_reg = RST_INC;
   logic [PHASE_W-1:0]   duty_reg = RST_DUTY;
   logic [AMP_W-1:0]     amp_reg = RST_AMP;
   logic [LFO_AMP_W-1:0] lfo_amp_reg = RST_LFO_AMP;
   logic [PHASE_W-1:0]   audio_ph = '0;
   logic [PHASE_W-1:0]   lfo_ph = '0;

   osc_sample_type expected_samples[$];

   int errors = 0;
   int ticks_sent = 0;
   int samples_checked = 0;
   int csr_writes = 0;
   int settings_used = 0;
   int burst_left = 0;
   int stall_left = 0;
   int stall_mode = 0;

   pulse_saw_oscillator_with_lfo u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic void apply_reg_write(logic [CSR_IDX_W-1:0] idx,
                                           logic [CSR_DATA_W-1:0] data);
      logic [PHASE_W-1:0] d;
      d = data[PHASE_W-1:0];
      case (idx)
         REG_WAVE_MODE: mode_reg = data[MODE_W-1:0];
         REG_PHASE_INC: inc_reg = data[PHASE_W-1:0];
         REG_DUTY: begin
            if (d < DUTY_MIN) d = DUTY_MIN;
            if (d > DUTY_MAX) d = DUTY_MAX;
            duty_reg = d;
         end
         REG_AMPLITUDE: amp_reg = data[AMP_W-1:0];
         REG_LFO_AMP: lfo_amp_reg = data[LFO_AMP_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic osc_sample_type predict_tick(logic step_audio, logic step_lfo);
      osc_sample_type s;
      longint a;
      longint l;
      longint d;
      logic [PHASE_W:0] half;
      a = 0;
      l = 0;
      if (step_audio && (mode_reg == MODE_PULSE || mode_reg == MODE_SAW)) begin
         audio_ph = PHASE_W'(audio_ph + inc_reg);
         if (mode_reg == MODE_PULSE) begin
            a = (audio_ph < duty_reg) ? longint'(amp_reg) : -longint'(amp_reg);
         end else begin
            d = longint'(audio_ph) - FX_HALF;
            a = ((d * longint'(amp_reg) + FX_HALF) >>> FRAC_BITS) * 2;
         end
         a = clip(a, AUDIO_LO, AUDIO_HI);
      end
      if (step_lfo) begin
         half = ({1'b0, inc_reg} + 1'b1) >> 1;
         lfo_ph = PHASE_W'(lfo_ph + half);
         l = (longint'(lfo_ph) < FX_HALF) ? longint'(lfo_amp_reg)
                                          : -longint'(lfo_amp_reg);
         l = clip(l, LFO_LO, LFO_HI);
      end
      s.audio = a[AUDIO_W-1:0];
      s.lfo = l[LFO_W-1:0];
      return s;
   endfunction

   // sender: bursts of random length separated by random gaps
   task automatic send_tick(logic step_audio, logic step_lfo);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W-2){1'b0}}, step_lfo, step_audio};
      do @(posedge clock); while (req_tready !== 1'b1);
      expected_samples.push_back(predict_tick(step_audio, step_lfo));
      ticks_sent++;
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // csr_valid stays high across back-to-back writes; csr_release drops it
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      apply_reg_write(idx, data);
      csr_writes++;
   endtask

   task automatic csr_release();
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // pick the increment that lands the audio phase exactly on target
   task automatic steer_audio_phase(logic [PHASE_W-1:0] target, logic step_lfo);
      wait_results_drained();
      write_reg(REG_PHASE_INC, CSR_DATA_W'(PHASE_W'(target - audio_ph)));
      csr_release();
      send_tick(1'b1, step_lfo);
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_setting(int idx);
      logic [CSR_DATA_W-1:0] v;
      int pick;
      v = CSR_DATA_W'($urandom);
      pick = $urandom_range(0, 9);
      case (idx)
         REG_WAVE_MODE: begin
            if (pick < 4) v[MODE_W-1:0] = MODE_PULSE;
            else if (pick < 8) v[MODE_W-1:0] = MODE_SAW;
            else if (v[MODE_W-1:0] < MODE_SILENT) v[MODE_W-1:0] = MODE_SILENT_ALT;
         end
         REG_PHASE_INC: begin
            case (pick)
               0: v[PHASE_W-1:0] = '0;
               1: v[PHASE_W-1:0] = '1;
               2: v[PHASE_W-1:0] = PHASE_W'(1);
               3, 4: v[PHASE_W-1:0] = PHASE_W'($urandom_range(1, 2000));
               default: ;
            endcase
         end
         REG_DUTY: begin
            case (pick)
               0: v[PHASE_W-1:0] = '0;
               1: v[PHASE_W-1:0] = '1;
               2: v[PHASE_W-1:0] = DUTY_MIN;
               3: v[PHASE_W-1:0] = DUTY_MAX;
               4: v[PHASE_W-1:0] = DUTY_MIN - 1'b1;
               5: v[PHASE_W-1:0] = DUTY_MAX + 1'b1;
               default: ;
            endcase
         end
         REG_AMPLITUDE: begin
            case (pick)
               0: v[AMP_W-1:0] = '0;
               1, 2: v[AMP_W-1:0] = '1;
               3: v[AMP_W-1:0] = RST_AMP;
               default: ;
            endcase
         end
         REG_LFO_AMP: begin
            if (pick == 0) v = '0;
            else if (pick == 1) v = '1;
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic test_reset_defaults();
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
   endtask

   task automatic test_pulse_duty();
      wait_results_drained();
      write_reg(REG_DUTY, '0);
      write_reg(REG_AMPLITUDE, '1);
      write_reg(REG_PHASE_INC, CSR_DATA_W'(16'hFFFF));
      csr_release();
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b1);
      steer_audio_phase(DUTY_MIN - 1'b1, 1'b0);
      steer_audio_phase(DUTY_MIN, 1'b1);
      wait_results_drained();
      write_reg(REG_DUTY, '1);
      write_reg(REG_AMPLITUDE, '0);
      write_reg(REG_PHASE_INC, '0);
      csr_release();
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
   endtask

   task automatic test_saw_extremes();
      wait_results_drained();
      write_reg(REG_WAVE_MODE, CSR_DATA_W'(MODE_SAW));
      write_reg(REG_AMPLITUDE, CSR_DATA_W'({AMP_W{1'b1}}));
      write_reg(REG_LFO_AMP, '1);
      csr_release();
      steer_audio_phase('0, 1'b1);
      steer_audio_phase('1, 1'b1);
      steer_audio_phase(16'h8000, 1'b1);
      steer_audio_phase(16'h7FFF, 1'b0);
      wait_results_drained();
      write_reg(REG_AMPLITUDE, CSR_DATA_W'(RST_AMP));
      write_reg(REG_LFO_AMP, '0);
      csr_release();
      steer_audio_phase('0, 1'b1);
      steer_audio_phase('1, 1'b1);
      wait_results_drained();
      write_reg(REG_AMPLITUDE, '0);
      csr_release();
      send_tick(1'b1, 1'b1);
   endtask

   task automatic test_silent_modes();
      wait_results_drained();
      write_reg(REG_WAVE_MODE, CSR_DATA_W'(MODE_SILENT));
      write_reg(REG_AMPLITUDE, CSR_DATA_W'(RST_AMP));
      write_reg(REG_LFO_AMP, CSR_DATA_W'(RST_LFO_AMP));
      write_reg(REG_PHASE_INC, CSR_DATA_W'(16'h1234));
      csr_release();
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      wait_results_drained();
      write_reg(REG_WAVE_MODE, CSR_DATA_W'(MODE_SILENT_ALT));
      csr_release();
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
   endtask

   task automatic test_unused_indexes();
      wait_results_drained();
      write_reg(REG_WAVE_MODE, CSR_DATA_W'(MODE_PULSE));
      for (int i = NUM_REGS; i < 2 ** CSR_IDX_W; i++) write_reg(CSR_IDX_W'(i), '1);
      csr_release();
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b1);
   endtask

   task automatic test_random_ticks();
      for (int p = 0; p < 12; p++) begin
         wait_results_drained();
         for (int r = REG_WAVE_MODE; r <= REG_LFO_AMP; r++) begin
            write_reg(CSR_IDX_W'(r), random_setting(r));
         end
         if ($urandom_range(0, 2) == 0) begin
            write_reg(CSR_IDX_W'($urandom_range(NUM_REGS, 2 ** CSR_IDX_W - 1)),
                      CSR_DATA_W'($urandom));
         end
         csr_release();
         for (int i = 0; i < 80; i++) begin
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // receiver: alternates between no stalls, light stalls and long stalls
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(10, 60);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      osc_sample_type want;
      logic [AUDIO_W-1:0] got_audio;
      logic [LFO_W-1:0] got_lfo;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got_audio = rsp_tdata[AUDIO_W-1:0];
         got_lfo = rsp_tdata[AUDIO_W +: LFO_W];
         if (expected_samples.size() == 0) begin
            $error("unexpected result transfer: audio_sample %0d lfo_sample %0d",
                   $signed(got_audio), $signed(got_lfo));
            errors++;
         end else begin
            want = expected_samples.pop_front();
            samples_checked++;
            if (got_audio !== want.audio) begin
               $error("audio_sample: expected %0d, actual %0d",
                      want.audio, $signed(got_audio));
               errors++;
            end
            if (got_lfo !== want.lfo) begin
               $error("lfo_sample: expected %0d, actual %0d",
                      want.lfo, $signed(got_lfo));
               errors++;
            end
            if (rsp_tdata[RSP_DATA_W-1:AUDIO_W+LFO_W] !== '0) begin
               $error("rsp_tdata padding: expected 0, actual %0h",
                      rsp_tdata[RSP_DATA_W-1:AUDIO_W+LFO_W]);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_pulse_duty();
      test_saw_extremes();
      test_silent_modes();
      test_unused_indexes();
      test_random_ticks();
      wait_results_drained();
      if (expected_samples.size() != 0) begin
         $error("%0d expected results never arrived", expected_samples.size());
         errors++;
      end
      $display("Covered %0d ticks and %0d checked results across %0d register settings",
               ticks_sent, samples_checked, settings_used);
      $display("(%0d register writes), pulse, sawtooth and silent modes, %0d mismatches.",
               csr_writes, errors);
      if (errors == 0) begin
         $display("** pulse_saw_oscillator_with_lfo: PASSED **");
      end else begin
         $display("** pulse_saw_oscillator_with_lfo: FAILED **");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("** pulse_saw_oscillator_with_lfo: FAILED **");
      $finish;
   end

endmodule

@@ pulse_saw_oscillator_with_lfo.f @@
hw/rtl/psaw_pkg.sv
hw/rtl/psaw_front.sv
hw/rtl/psaw_queue.sv
hw/rtl/psaw_back.sv
hw/rtl/pulse_saw_oscillator_with_lfo.sv
verif/tb_pulse_saw_oscillator_with_lfo.sv
